FILE: hdl/drt_pkg.sv
package drt_pkg;

    localparam int POS_W       = 13;
    localparam int DIM_W       = 14;
    localparam int SUM_W       = DIM_W + 1;
    localparam int ENTRIES_DEF = 4;
    localparam int CFG_IDX_W   = 1;

    localparam logic [DIM_W-1:0] WIN_MAX = DIM_W'(8192);

    localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_MARK  = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_CLIP,
        OP_TEST,
        OP_SIZE
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLIP,
        S_SCAN,
        S_MERGE,
        S_APPEND,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_cmd             command;
        logic [DIM_W-1:0] rect_x;
        logic [DIM_W-1:0] rect_y;
        logic [DIM_W-1:0] rect_width;
        logic [DIM_W-1:0] rect_height;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0] out_x;
        logic [POS_W-1:0] out_y;
        logic [DIM_W-1:0] out_width;
        logic [DIM_W-1:0] out_height;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_rect;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] right;
        logic [DIM_W-1:0] bottom;
    } t_box;

    typedef struct packed {
        logic             ignore;
        logic             hit;
        t_box             box;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] win_w;
        logic [DIM_W-1:0] win_h;
    } t_unit_res;

endpackage

FILE: hdl/dirty_rect_tracker_core.sv
// Add: busy after start while the shared unit clips the rectangle; unless it is
// ignored, stored entries are compared one at a time, then it is merged or appended.
// Mark-all, unused commands and an empty flush never raise busy.
// Flush: busy while results are emitted; results follow one per cycle, registered
// from the EMIT state and strobed for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears the table count, full mode and window.
module dirty_rect_tracker_core
    import drt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    output t_result              o_result,
    output logic                 o_result_valid,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    t_state           r_state;
    t_state           n_state;
    t_item            r_item;
    t_box             r_box;
    t_box             n_box;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_full;
    logic             n_full;
    logic [DIM_W-1:0] r_win_w;
    logic [DIM_W-1:0] r_win_h;
    t_result          r_out;
    t_result          n_out;
    logic             r_out_valid;
    logic             n_out_valid;

    logic             accept;
    t_op              op;
    t_box             unit_a;
    t_unit_res        res;
    logic             we;
    logic [IDX_W-1:0] waddr;
    t_rect            wdata;
    t_rect            rdata;
    logic             idx_last;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign o_result       = r_out;
    assign o_result_valid = r_out_valid;
    assign idx_last    = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;

    always_comb begin
        case (r_state)
            S_CLIP:  op = OP_CLIP;
            S_SCAN:  op = OP_TEST;
            default: op = OP_SIZE;
        endcase
        if (r_state == S_CLIP) begin
            unit_a = '{x: r_item.rect_x, y: r_item.rect_y, right: '0, bottom: '0};
        end else begin
            unit_a = r_box;
        end
    end

    drt_unit u_unit (
        .i_op    (op),
        .i_win_w (r_win_w),
        .i_win_h (r_win_h),
        .i_full  (r_full),
        .i_a     (unit_a),
        .i_w     (r_item.rect_width),
        .i_h     (r_item.rect_height),
        .i_ent   (rdata),
        .o_res   (res)
    );

    drt_table #(
        .WIDTH  ($bits(t_rect)),
        .DEPTH  (ENTRIES),
        .ADDR_W (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (n_idx),
        .o_rdata (rdata)
    );

    assign wdata = '{x: r_box.x[POS_W-1:0], y: r_box.y[POS_W-1:0], w: res.w, h: res.h};

    always_comb begin
        n_state     = r_state;
        n_box       = r_box;
        n_idx       = r_idx;
        n_count     = r_count;
        n_full      = r_full;
        n_out       = r_out;
        n_out_valid = 1'b0;
        we          = 1'b0;
        waddr       = r_idx;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    case (i_item.command)
                        CMD_ADD:  n_state = S_CLIP;
                        CMD_MARK: begin
                            n_count = '0;
                            n_full  = 1'b1;
                        end
                        CMD_FLUSH: begin
                            if (r_full || (r_count != '0)) begin
                                n_state = S_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CLIP: begin
                if (res.ignore) begin
                    n_state = S_IDLE;
                end else begin
                    n_box   = res.box;
                    n_state = (r_count == '0) ? S_APPEND : S_SCAN;
                end
            end
            S_SCAN: begin
                if (res.hit) begin
                    n_box   = res.box;
                    n_state = S_MERGE;
                end else if (idx_last) begin
                    n_state = S_APPEND;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_MERGE: begin
                we      = 1'b1;
                n_state = S_IDLE;
            end
            S_APPEND: begin
                if (r_count >= CNT_W'(ENTRIES)) begin
                    n_count = '0;
                    n_full  = 1'b1;
                end else begin
                    we      = 1'b1;
                    waddr   = r_count[IDX_W-1:0];
                    n_count = r_count + CNT_W'(1);
                end
                n_state = S_IDLE;
            end
            S_EMIT: begin
                n_out_valid = 1'b1;
                if (r_full) begin
                    n_out   = '{out_x: '0, out_y: '0, out_width: res.win_w,
                                out_height: res.win_h, last: 1'b1};
                    n_full  = 1'b0;
                    n_count = '0;
                    n_state = S_IDLE;
                end else begin
                    n_out = '{out_x: rdata.x, out_y: rdata.y, out_width: rdata.w,
                              out_height: rdata.h, last: idx_last};
                    if (idx_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
            r_win_w     <= '0;
            r_win_h     <= '0;
            r_idx       <= '0;
        end else begin
            r_count     <= n_count;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_WIN_WIDTH:  r_win_w <= i_cfg_data;
                    REG_WIN_HEIGHT: r_win_h <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_box <= n_box;
        r_out <= n_out;
    end

endmodule

FILE: hdl/drt_unit.sv
module drt_unit
    import drt_pkg::*;
(
    input  t_op              i_op,
    input  logic [DIM_W-1:0] i_win_w,
    input  logic [DIM_W-1:0] i_win_h,
    input  logic             i_full,
    input  t_box             i_a,
    input  logic [DIM_W-1:0] i_w,
    input  logic [DIM_W-1:0] i_h,
    input  t_rect            i_ent,
    output t_unit_res        o_res
);

    logic             clip;
    logic [DIM_W-1:0] ww;
    logic [DIM_W-1:0] wh;
    logic [DIM_W-1:0] sub_a0;
    logic [DIM_W-1:0] sub_a1;
    logic [DIM_W-1:0] sub0;
    logic [DIM_W-1:0] sub1;
    logic [DIM_W-1:0] wc;
    logic [DIM_W-1:0] hc;
    logic [DIM_W-1:0] add_a0;
    logic [DIM_W-1:0] add_a1;
    logic [DIM_W-1:0] add_b0;
    logic [DIM_W-1:0] add_b1;
    logic [SUM_W-1:0] add0;
    logic [SUM_W-1:0] add1;
    logic [DIM_W-1:0] ex;
    logic [DIM_W-1:0] ey;
    logic             miss;
    t_box             mbox;

    assign clip = (i_op == OP_CLIP);
    assign ww   = (i_win_w > WIN_MAX) ? WIN_MAX : i_win_w;
    assign wh   = (i_win_h > WIN_MAX) ? WIN_MAX : i_win_h;

    assign sub_a0 = clip ? ww : i_a.right;
    assign sub_a1 = clip ? wh : i_a.bottom;
    assign sub0   = sub_a0 - i_a.x;
    assign sub1   = sub_a1 - i_a.y;

    assign wc = (i_w > sub0) ? sub0 : i_w;
    assign hc = (i_h > sub1) ? sub1 : i_h;

    assign ex     = {1'b0, i_ent.x};
    assign ey     = {1'b0, i_ent.y};
    assign add_a0 = clip ? i_a.x : ex;
    assign add_a1 = clip ? i_a.y : ey;
    assign add_b0 = clip ? wc : i_ent.w;
    assign add_b1 = clip ? hc : i_ent.h;
    assign add0   = {1'b0, add_a0} + {1'b0, add_b0};
    assign add1   = {1'b0, add_a1} + {1'b0, add_b1};

    assign miss = (i_a.right < ex) || (add0 < {1'b0, i_a.x})
               || (i_a.bottom < ey) || (add1 < {1'b0, i_a.y});

    always_comb begin
        mbox.x      = (i_a.x > ex) ? ex : i_a.x;
        mbox.y      = (i_a.y > ey) ? ey : i_a.y;
        mbox.right  = ({1'b0, i_a.right} < add0) ? add0[DIM_W-1:0] : i_a.right;
        mbox.bottom = ({1'b0, i_a.bottom} < add1) ? add1[DIM_W-1:0] : i_a.bottom;
    end

    always_comb begin
        o_res.ignore = i_full || (i_w == '0) || (i_h == '0)
                    || (i_a.x >= ww) || (i_a.y >= wh);
        o_res.hit    = !miss;
        o_res.w      = sub0;
        o_res.h      = sub1;
        o_res.win_w  = ww;
        o_res.win_h  = wh;
        if (clip) begin
            o_res.box = '{x: i_a.x, y: i_a.y,
                          right: add0[DIM_W-1:0], bottom: add1[DIM_W-1:0]};
        end else begin
            o_res.box = mbox;
        end
    end

endmodule

FILE: hdl/drt_table.sv
module drt_table
    import drt_pkg::*;
#(
    parameter int WIDTH  = $bits(t_rect),
    parameter int DEPTH  = ENTRIES_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/rect_check_pkg.sv
`timescale 1ns / 100ps
package rect_check_pkg;
    import drt_pkg::*;

    class damage_scoreboard;
        t_rect       rects[ENTRIES_DEF];
        int unsigned rect_count;
        bit          whole_window;
        int unsigned win_w;
        int unsigned win_h;
        t_result     pending[$];
        int unsigned mismatches;
        int unsigned rects_checked;
        int unsigned commands;
        int unsigned flushes;
        int unsigned merges;
        int unsigned appends;
        int unsigned overflows;
        int unsigned ignored;

        function new();
            rect_count    = 0;
            whole_window  = 1'b0;
            win_w         = 0;
            win_h         = 0;
            mismatches    = 0;
            rects_checked = 0;
            commands      = 0;
            flushes       = 0;
            merges        = 0;
            appends       = 0;
            overflows     = 0;
            ignored       = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v);
            return (v > WIN_MAX) ? int'(WIN_MAX) : v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            if (idx == REG_WIN_WIDTH) begin
                win_w = data;
            end else begin
                win_h = data;
            end
        endfunction

        function void add_rect(t_item it);
            int unsigned ww, wh, x, y, w, h, rgt, bot, er, eb;
            int unsigned i;
            ww = clamp_dim(win_w);
            wh = clamp_dim(win_h);
            x  = it.rect_x;
            y  = it.rect_y;
            w  = it.rect_width;
            h  = it.rect_height;
            if (whole_window || w == 0 || h == 0 || x >= ww || y >= wh) begin
                ignored++;
                return;
            end
            if (w > ww - x) w = ww - x;
            if (h > wh - y) h = wh - y;
            rgt = x + w;
            bot = y + h;
            for (i = 0; i < rect_count && i < ENTRIES_DEF; i++) begin
                er = rects[i].x + rects[i].w;
                eb = rects[i].y + rects[i].h;
                if (rgt < rects[i].x || er < x || bot < rects[i].y || eb < y) continue;
                if (x > rects[i].x) x = rects[i].x;
                if (y > rects[i].y) y = rects[i].y;
                if (rgt < er) rgt = er;
                if (bot < eb) bot = eb;
                rects[i].x = x[POS_W-1:0];
                rects[i].y = y[POS_W-1:0];
                rects[i].w = DIM_W'(rgt - x);
                rects[i].h = DIM_W'(bot - y);
                merges++;
                return;
            end
            if (rect_count >= ENTRIES_DEF) begin
                rect_count   = 0;
                whole_window = 1'b1;
                overflows++;
                return;
            end
            rects[rect_count].x = x[POS_W-1:0];
            rects[rect_count].y = y[POS_W-1:0];
            rects[rect_count].w = w[DIM_W-1:0];
            rects[rect_count].h = h[DIM_W-1:0];
            rect_count++;
            appends++;
        endfunction

        function void note_item(t_item it);
            t_result     r;
            int unsigned i;
            commands++;
            case (it.command)
                CMD_ADD: begin
                    add_rect(it);
                end
                CMD_MARK: begin
                    rect_count   = 0;
                    whole_window = 1'b1;
                end
                CMD_FLUSH: begin
                    if (whole_window) begin
                        r.out_x      = '0;
                        r.out_y      = '0;
                        r.out_width  = DIM_W'(clamp_dim(win_w));
                        r.out_height = DIM_W'(clamp_dim(win_h));
                        r.last       = 1'b1;
                        pending.push_back(r);
                    end else begin
                        for (i = 0; i < rect_count && i < ENTRIES_DEF; i++) begin
                            r.out_x      = rects[i].x;
                            r.out_y      = rects[i].y;
                            r.out_width  = rects[i].w;
                            r.out_height = rects[i].h;
                            r.last       = (i + 1 == rect_count);
                            pending.push_back(r);
                        end
                    end
                    rect_count   = 0;
                    whole_window = 1'b0;
                    flushes++;
                end
                default: begin
                end
            endcase
        endfunction

        function void check_rect(t_result got);
            t_result want;
            rects_checked++;
            if (pending.size() == 0) begin
                $error("unexpected rectangle x=%0d y=%0d w=%0d h=%0d last=%0d",
                       got.out_x, got.out_y, got.out_width, got.out_height, got.last);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.out_x !== want.out_x) begin
                $error("out_x: expected %0d, got %0d", want.out_x, got.out_x);
                mismatches++;
            end
            if (got.out_y !== want.out_y) begin
                $error("out_y: expected %0d, got %0d", want.out_y, got.out_y);
                mismatches++;
            end
            if (got.out_width !== want.out_width) begin
                $error("out_width: expected %0d, got %0d", want.out_width, got.out_width);
                mismatches++;
            end
            if (got.out_height !== want.out_height) begin
                $error("out_height: expected %0d, got %0d", want.out_height, got.out_height);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

endpackage

FILE: tb/tb_dirty_rect_tracker_core.sv
`timescale 1ns / 100ps
module tb_dirty_rect_tracker_core;
    import drt_pkg::*;
    import rect_check_pkg::*;

    localparam int STALL_LIMIT      = 1000;
    localparam int SETTLE_CYCLES    = ENTRIES_DEF + 8;
    localparam int PHASES           = 4;
    localparam int ITEMS_PER_PHASE  = 28;
    localparam int FIELD_MAX        = 16383;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic                 busy;
    t_item                i_item         = '0;
    t_result              o_result;
    logic                 o_result_valid;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [DIM_W-1:0]     i_cfg_data     = '0;

    damage_scoreboard board = new();
    int unsigned      idle_cycles = 0;
    bit               burst_mode  = 1'b0;

    dirty_rect_tracker_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result       (o_result),
        .o_result_valid (o_result_valid),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            board.check_rect(o_result);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_result_valid === 1'b1 ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (burst_mode) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int unsigned any_field();
        return $urandom_range(0, FIELD_MAX);
    endfunction

    task automatic send_cmd(t_cmd cmd, int unsigned x, int unsigned y,
                            int unsigned w, int unsigned h);
        t_item       it;
        int unsigned gap;
        it.command     = cmd;
        it.rect_x      = x[DIM_W-1:0];
        it.rect_y      = y[DIM_W-1:0];
        it.rect_width  = w[DIM_W-1:0];
        it.rect_height = h[DIM_W-1:0];
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        board.note_item(it);
        gap = pick_gap();
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until every pending rectangle has come out, then let the block settle
    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[DIM_W-1:0];
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        board.write_reg(idx, value[DIM_W-1:0]);
    endtask

    task automatic write_window(int unsigned ww, int unsigned wh);
        write_reg(REG_WIN_WIDTH, ww);
        write_reg(REG_WIN_HEIGHT, wh);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_add();
        int unsigned ww, wh, x, y, w, h, roll;
        ww   = board.clamp_dim(board.win_w);
        wh   = board.clamp_dim(board.win_h);
        roll = $urandom_range(0, 99);
        if (roll < 12 || ww == 0 || wh == 0) begin
            x = any_field();
            y = any_field();
            w = any_field();
            h = any_field();
        end else begin
            // cluster near the origin so merges and appends both happen
            x = $urandom_range(0, (ww > 160) ? 160 : ww - 1);
            y = $urandom_range(0, (wh > 160) ? 160 : wh - 1);
            if (roll < 30) x = $urandom_range(0, ww - 1);
            if (roll < 36) y = $urandom_range(0, wh - 1);
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 24);
            if (roll >= 40 && roll < 46) w = any_field();
            if (roll >= 44 && roll < 50) h = any_field();
            if (roll >= 96) begin
                if (roll[0]) w = 0;
                else h = 0;
            end
        end
        send_cmd(CMD_ADD, x, y, w, h);
    endtask

    task automatic send_random_item();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 68) begin
            send_random_add();
        end else if (roll < 86) begin
            send_cmd(CMD_FLUSH, any_field(), any_field(), any_field(), any_field());
        end else if (roll < 93) begin
            send_cmd(CMD_MARK, any_field(), any_field(), any_field(), any_field());
        end else begin
            send_cmd(CMD_NONE, any_field(), any_field(), any_field(), any_field());
        end
    endtask

    initial begin
        int unsigned phase_w[PHASES];
        int unsigned phase_h[PHASES];
        phase_w[0] = 8192;
        phase_h[0] = 8192;
        phase_w[1] = FIELD_MAX;
        phase_h[1] = 200;
        phase_w[2] = 1;
        phase_h[2] = 9000;
        phase_w[3] = $urandom_range(2, 8192);
        phase_h[3] = $urandom_range(2, 8192);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero-size window
        write_window(0, 0);
        send_cmd(CMD_ADD, 0, 0, 5, 5);
        send_cmd(CMD_FLUSH, 0, 0, 0, 0);
        send_cmd(CMD_MARK, 0, 0, 0, 0);
        send_cmd(CMD_FLUSH, 0, 0, 0, 0);
        send_cmd(CMD_NONE, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
        drain();

        // oversized window saturates
        write_window(FIELD_MAX, FIELD_MAX);
        send_cmd(CMD_ADD, 0, 0, FIELD_MAX, FIELD_MAX);
        send_cmd(CMD_FLUSH, 0, 0, 0, 0);
        send_cmd(CMD_ADD, 8191, 8191, 1, 1);
        send_cmd(CMD_ADD, 8192, 0, 1, 1);
        send_cmd(CMD_ADD, 0, 0, 0, 5);
        send_cmd(CMD_ADD, 0, 0, 5, 0);
        send_cmd(CMD_ADD, 0, 0, 10, 10);
        send_cmd(CMD_ADD, 10, 0, 5, 5);
        send_cmd(CMD_ADD, 20, 0, 2, 2);
        send_cmd(CMD_ADD, 30, 0, 2, 2);
        send_cmd(CMD_ADD, 22, 0, 8, 1);
        send_cmd(CMD_ADD, 5000, 5000, 3, 3);
        send_cmd(CMD_ADD, 0, 0, 1, 1);
        send_cmd(CMD_FLUSH, 0, 0, 0, 0);
        send_cmd(CMD_ADD, 100, 100, 4, 4);
        drain();

        // shrink the window under a stored entry
        write_window(9000, 50);
        send_cmd(CMD_FLUSH, 0, 0, 0, 0);
        send_cmd(CMD_ADD, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
        send_cmd(CMD_ADD, 8191, 49, FIELD_MAX, FIELD_MAX);
        send_cmd(CMD_FLUSH, 0, 0, 0, 0);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_window(phase_w[p], phase_h[p]);
            burst_mode = (p == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 0 && n == ITEMS_PER_PHASE / 2) drain();
                send_random_item();
            end
        end
        send_cmd(CMD_FLUSH, 0, 0, 0, 0);
        drain();

        $display("Ran %0d commands over %0d window settings: %0d flushes, %0d merges, %0d appends",
                 board.commands, PHASES + 3, board.flushes, board.merges, board.appends);
        $display("%0d table overflows, %0d ignored adds, %0d rectangles checked",
                 board.overflows, board.ignored, board.rects_checked);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
